FILE: rtl/mips_ex_pkg.sv
// ----------------------------------------------------------------------------
// mips_ex_pkg
// Shared types and fixed field widths of the instruction executor.
// ----------------------------------------------------------------------------
package mips_ex_pkg;

  localparam int CMD_BITS     = 3;
  localparam int REG_IDX_BITS = 5;
  localparam int IMM_BITS     = 16;
  localparam int OUT_VAL_BITS = 32;

  // operation codes; code 7 is unused and behaves as a no-op
  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD  = 3'd0,
    CMD_ADDI = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_LW   = 3'd4,
    CMD_SW   = 3'd5,
    CMD_BEQ  = 3'd6
  } cmd_t;

endpackage

FILE: rtl/mini_mips_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// mini_mips_instruction_executor_core
// Executes decoded add/addi/sub/mul/lw/sw words against a register file and
// a data memory, one result word per instruction, strictly in order.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_valid/in_ready  | command, src_a, src_b, dest, immediate
//  out_    | out | out_valid/out_ready| reg_written, written_index,
//          |     |                    | written_value, addr_fault
//
//  Pipeline: S1 (operands, ALU, address, partial products, memory port), S2
//  (product sum, register write), output register. One word per cycle while
//  nothing stalls; a word reading the register of the mul just ahead of it
//  waits in S1 until that mul leaves S2.
//  Reset: register file cleared via valid bits; data memory swept word by
//  word with in_ready low. Stalls: out_ready low holds the output register,
//  then S2, then S1, then drops in_ready; nothing is lost.
//
module mini_mips_instruction_executor_core
  import mips_ex_pkg::*;
#(
  parameter int REG_COUNT = 32,
  parameter int MEM_WORDS = 512,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // instruction channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CMD_BITS-1:0]            in_command,
  input  logic [REG_IDX_BITS-1:0]        in_src_a,
  input  logic [REG_IDX_BITS-1:0]        in_src_b,
  input  logic [REG_IDX_BITS-1:0]        in_dest,
  input  logic signed [IMM_BITS-1:0]     in_immediate,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_reg_written,
  output logic [REG_IDX_BITS-1:0]        out_written_index,
  output logic signed [OUT_VAL_BITS-1:0] out_written_value,
  output logic                           out_addr_fault
);

  localparam int RIW = $clog2(REG_COUNT);   // register file index bits
  localparam int MAW = $clog2(MEM_WORDS);   // data memory index bits
  localparam int HL  = WORD_BITS / 2;       // low half of a multiplicand
  localparam int HH  = WORD_BITS - HL;      // high half

  // --------------------------------------------------------------------------
  // storage
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] rf_r   [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;            // entry written since reset
  logic [WORD_BITS-1:0] dmem_r [MEM_WORDS];

  // data memory clearing sweep
  logic           clr_busy_r;
  logic [MAW-1:0] clr_cnt_r;

  // --------------------------------------------------------------------------
  // pipeline registers
  // --------------------------------------------------------------------------
  logic                     s1_vld_r;
  cmd_t                     s1_cmd_r;
  logic [REG_IDX_BITS-1:0]  s1_src_a_r, s1_src_b_r, s1_dest_r;
  logic signed [IMM_BITS-1:0] s1_imm_r;
  logic [WORD_BITS-1:0]     opa_r, opb_r;     // raw rf read, or resolved on hold
  logic                     opa_zero_r, opb_zero_r;

  logic                     s2_vld_r;
  logic                     s2_wr_r, s2_mul_r, s2_ld_r, s2_fault_r;
  logic [REG_IDX_BITS-1:0]  s2_idx_r;
  logic [WORD_BITS-1:0]     s2_alu_r;
  logic [2*HL-1:0]          s2_pp_ll_r;
  logic [HH-1:0]            s2_pp_lh_r, s2_pp_hl_r;
  logic [WORD_BITS-1:0]     ld_q_r;

  // last register write, for the read that shared its clock edge
  logic                     wb_vld_r;
  logic [REG_IDX_BITS-1:0]  wb_idx_r;
  logic [WORD_BITS-1:0]     wb_val_r;

  logic                     out_vld_r;
  logic                     out_wr_r, out_fault_r;
  logic [REG_IDX_BITS-1:0]  out_idx_r;
  logic [OUT_VAL_BITS-1:0]  out_val_r;

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  logic in_acc, s2_adv, s2_open, s1_adv, s1_hold, stall_mul;
  logic out_free, uses_a, uses_b;

  assign out_free = !out_vld_r || out_ready;
  assign s2_adv   = s2_vld_r && out_free;
  assign s2_open  = !s2_vld_r || s2_adv;

  always_comb begin
    uses_a = 1'b0;
    uses_b = 1'b0;
    case (s1_cmd_r) inside
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_SW: begin
        uses_a = 1'b1;
        uses_b = 1'b1;
      end
      CMD_ADDI, CMD_LW: uses_a = 1'b1;
      default: ;
    endcase
  end

  // a mul result is only summed in S2: a dependant in S1 waits while the mul is in S2
  assign stall_mul = s1_vld_r && s2_vld_r && s2_mul_r && s2_wr_r &&
                     ((uses_a && s2_idx_r == s1_src_a_r) ||
                      (uses_b && s2_idx_r == s1_src_b_r));
  assign s1_adv   = s1_vld_r && s2_open && !stall_mul;
  assign s1_hold  = s1_vld_r && !s1_adv;
  assign in_ready = (!s1_vld_r || s1_adv) && !clr_busy_r;
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // S2 result (needed early for forwarding and the register write)
  // --------------------------------------------------------------------------
  logic [HH-1:0]        cross_sum;
  logic [WORD_BITS-1:0] mul_val, s2_val, s2_fwd_val;
  logic                 rf_we;

  assign cross_sum  = s2_pp_lh_r + s2_pp_hl_r;
  assign mul_val    = WORD_BITS'(s2_pp_ll_r) + {cross_sum, {HL{1'b0}}};
  assign s2_fwd_val = s2_ld_r ? ld_q_r : s2_alu_r;
  assign s2_val     = s2_mul_r ? mul_val : s2_fwd_val;
  assign rf_we      = s2_adv && s2_wr_r;

  // --------------------------------------------------------------------------
  // S1: operand resolution
  // newest first: S2 word, then the write of the last edge, then the file
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] op_a, op_b;

  always_comb begin
    if (s2_vld_r && s2_wr_r && s2_idx_r == s1_src_a_r) begin
      op_a = s2_fwd_val;
    end else if (wb_vld_r && wb_idx_r == s1_src_a_r) begin
      op_a = wb_val_r;
    end else begin
      op_a = opa_zero_r ? '0 : opa_r;
    end
    if (s2_vld_r && s2_wr_r && s2_idx_r == s1_src_b_r) begin
      op_b = s2_fwd_val;
    end else if (wb_vld_r && wb_idx_r == s1_src_b_r) begin
      op_b = wb_val_r;
    end else begin
      op_b = opb_zero_r ? '0 : opb_r;
    end
  end

  // --------------------------------------------------------------------------
  // S1: execute
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0]    imm_ext, sum_ai, alu_nxt;
  logic                    addr_bad, fault_nxt, wr_raw, wr_nxt;
  logic                    mul_nxt, ld_nxt, st_nxt;
  logic [REG_IDX_BITS-1:0] idx_nxt;
  logic [MAW-1:0]          addr_idx;
  logic [2*HL-1:0]         pp_ll;
  logic [HL+HH-1:0]        pp_lh, pp_hl;
  logic                    ld_en, st_en;

  assign imm_ext  = WORD_BITS'(s1_imm_r);
  assign sum_ai   = op_a + imm_ext;           // addi value and lw/sw address
  assign addr_bad = sum_ai[WORD_BITS-1] ||
                    ({1'b0, sum_ai} >= (WORD_BITS+1)'(MEM_WORDS));
  assign addr_idx = sum_ai[MAW-1:0];

  // low WORD_BITS of the product from three half-width products
  assign pp_ll = op_a[HL-1:0] * op_b[HL-1:0];
  assign pp_lh = op_a[HL-1:0] * op_b[WORD_BITS-1:HL];
  assign pp_hl = op_a[WORD_BITS-1:HL] * op_b[HL-1:0];

  always_comb begin
    alu_nxt   = sum_ai;
    wr_raw    = 1'b0;
    idx_nxt   = s1_dest_r;
    mul_nxt   = 1'b0;
    ld_nxt    = 1'b0;
    st_nxt    = 1'b0;
    fault_nxt = 1'b0;
    unique case (s1_cmd_r)
      CMD_ADD: begin
        alu_nxt = op_a + op_b;
        wr_raw  = 1'b1;
      end
      CMD_ADDI: begin
        wr_raw  = 1'b1;
        idx_nxt = s1_src_b_r;
      end
      CMD_SUB: begin
        alu_nxt = op_a - op_b;
        wr_raw  = 1'b1;
      end
      CMD_MUL: begin
        wr_raw  = 1'b1;
        mul_nxt = 1'b1;
      end
      CMD_LW: begin
        fault_nxt = addr_bad;
        wr_raw    = !addr_bad;
        ld_nxt    = 1'b1;
        idx_nxt   = s1_src_b_r;
      end
      CMD_SW: begin
        fault_nxt = addr_bad;
        st_nxt    = !addr_bad;
      end
      default: ;
    endcase
    // writes beyond the file are dropped
    wr_nxt = wr_raw && (32'(idx_nxt) < REG_COUNT);
  end

  assign ld_en = s1_adv && ld_nxt && !addr_bad;
  assign st_en = s1_adv && st_nxt;

  // --------------------------------------------------------------------------
  // register file: one write port, two registered read ports
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_r[s2_idx_r[RIW-1:0]] <= s2_val;
    end
    if (in_acc) begin
      opa_r      <= rf_r[in_src_a[RIW-1:0]];
      opb_r      <= rf_r[in_src_b[RIW-1:0]];
      opa_zero_r <= !((32'(in_src_a) < REG_COUNT) && rf_vld_r[in_src_a[RIW-1:0]]);
      opb_zero_r <= !((32'(in_src_b) < REG_COUNT) && rf_vld_r[in_src_b[RIW-1:0]]);
    end else if (s1_hold) begin
      // keep operands current with writes that land while waiting
      opa_r      <= op_a;
      opb_r      <= op_b;
      opa_zero_r <= 1'b0;
      opb_zero_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      wb_vld_r <= 1'b0;
    end else if (rf_we) begin
      rf_vld_r[s2_idx_r[RIW-1:0]] <= 1'b1;
      wb_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      wb_idx_r <= s2_idx_r;
      wb_val_r <= s2_val;
    end
  end

  // --------------------------------------------------------------------------
  // data memory: single port, cleared by a sweep after reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem_r[clr_cnt_r] <= '0;
    end else if (st_en) begin
      dmem_r[addr_idx] <= op_b;
    end
    if (ld_en) begin
      ld_q_r <= dmem_r[addr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == MAW'(MEM_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage valids
  // --------------------------------------------------------------------------
  logic s1_vld_nxt, s2_vld_nxt, out_vld_nxt;

  always_comb begin
    s1_vld_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    s2_vld_nxt  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_vld_r);
    out_vld_nxt = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= cmd_t'(in_command);
      s1_src_a_r <= in_src_a;
      s1_src_b_r <= in_src_b;
      s1_dest_r  <= in_dest;
      s1_imm_r   <= in_immediate;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_wr_r    <= wr_nxt;
      s2_mul_r   <= mul_nxt;
      s2_ld_r    <= ld_nxt;
      s2_fault_r <= fault_nxt;
      s2_idx_r   <= idx_nxt;
      s2_alu_r   <= alu_nxt;
      s2_pp_ll_r <= pp_ll;
      s2_pp_lh_r <= pp_lh[HH-1:0];
      s2_pp_hl_r <= pp_hl[HH-1:0];
    end
  end

  // low OUT_VAL_BITS of the word, zero-extended when the word is narrower
  logic [OUT_VAL_BITS+WORD_BITS-1:0] val_ext;
  assign val_ext = {{OUT_VAL_BITS{1'b0}}, s2_val};

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_wr_r    <= s2_wr_r;
      out_idx_r   <= s2_wr_r ? s2_idx_r : '0;
      out_val_r   <= s2_wr_r ? val_ext[OUT_VAL_BITS-1:0] : '0;
      out_fault_r <= s2_fault_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_reg_written   = out_wr_r;
  assign out_written_index = out_idx_r;
  assign out_written_value = out_val_r;
  assign out_addr_fault    = out_fault_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("word accepted during data memory clear");

  a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_fault_r) |-> !s2_wr_r)
    else $error("faulting access also writes a register");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (32'(s2_idx_r) < REG_COUNT))
    else $error("register write beyond the file");

  a_s2_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && !s2_adv) |=> s2_vld_r)
    else $error("stalled S2 word lost");

  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_cnt_r) == MAW'(MEM_WORDS - 1)))
    else $error("clear sweep ended early");

endmodule
